### hw/rtl/swc_pkg.sv
// Shared constants and register codes for the stream word censor.
package swc_pkg;

    // Default longest pattern the window can hold
    localparam int MAX_PATTERN_DEF = 32;

    // Pattern storage: four 64-bit words, little-endian bytes
    localparam int PAT_BYTES  = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int PLEN_W     = 6;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd4;

    // Replacement text "CENSORED"
    localparam int REPL_LEN = 8;
    localparam logic [7:0] REPL_TEXT [REPL_LEN] = '{
        8'h43, 8'h45, 8'h4E, 8'h53, 8'h4F, 8'h52, 8'h45, 8'h44
    };

endpackage

### hw/rtl/swc_window.sv
// Match window: pattern registers, window shift, compare and burst selection.
module swc_window #(
    parameter int MAX_PATTERN = 32,
    parameter int BURST_D     = 32,
    parameter int BCNT_W      = 6
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [swc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [swc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            step,
    input  logic [7:0]                      item_byte,
    input  logic                            item_eos,
    output logic [7:0]                      ld_data [BURST_D],
    output logic [BCNT_W-1:0]               ld_count,
    output logic                            ld_eos
);
    import swc_pkg::*;

    localparam int CNT_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [PAT_BYTES*8-1:0] pattern_reg;
    logic [PLEN_W-1:0]      plen_reg;
    logic [7:0]             win_reg  [MAX_PATTERN];
    logic [7:0]             win_next [MAX_PATTERN];
    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       cnt_next;

    logic [7:0]       pat  [MAX_PATTERN];
    logic [7:0]       app  [MAX_PATTERN];
    logic [CNT_W-1:0] len;
    logic [CNT_W-1:0] cnt_app;
    logic [CNT_W-1:0] n_pop;
    logic             eq_ok;
    logic             censor;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            plen_reg    <= PLEN_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PATTERN_WORD_0: pattern_reg[0*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
                REG_PATTERN_WORD_1: pattern_reg[1*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
                REG_PATTERN_WORD_2: pattern_reg[2*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
                REG_PATTERN_WORD_3: pattern_reg[3*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
                REG_PATTERN_LENGTH: plen_reg <= cfg_data[PLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective length: zero acts as one, clamp to window size
    always_comb
    begin
        logic [7:0] len_ext;
        len_ext = (plen_reg == '0) ? 8'd1 : {{(8-PLEN_W){1'b0}}, plen_reg};
        if (len_ext > 8'(MAX_PATTERN))
            len_ext = 8'(MAX_PATTERN);
        len = CNT_W'(len_ext);
    end

    // Pattern bytes beyond the stored words read as zero; window with new byte appended
    for (genvar g = 0; g < MAX_PATTERN; g++)
    begin : g_lane
        if (g < PAT_BYTES)
        begin : g_pat
            assign pat[g] = pattern_reg[8*g +: 8];
        end
        else
        begin : g_zero
            assign pat[g] = '0;
        end
        assign app[g] = (cnt_reg == CNT_W'(g)) ? item_byte : win_reg[g];
    end

    assign cnt_app = cnt_reg + CNT_W'(1);

    // Parallel compare of the active window lanes
    always_comb
    begin
        eq_ok = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if (CNT_W'(i) < len && app[i] != pat[i])
                eq_ok = 1'b0;
        end
    end

    // Decide how many oldest bytes leave, or whether the replacement goes out
    always_comb
    begin
        censor = (cnt_app == len) && eq_ok;
        if (cnt_app > len)
            n_pop = cnt_app - (len - CNT_W'(1));
        else if (cnt_app == len && !eq_ok)
            n_pop = CNT_W'(1);
        else
            n_pop = '0;
        if (item_eos && !censor)
            n_pop = cnt_app;
        cnt_next = censor ? '0 : (cnt_app - n_pop);
    end

    // Shift the appended window down by the popped count
    always_comb
    begin
        logic [CNT_W:0] sidx;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            sidx = (CNT_W+1)'(i) + {1'b0, n_pop};
            win_next[i] = '0;
            if (sidx < (CNT_W+1)'(MAX_PATTERN))
                win_next[i] = app[sidx[IDX_W-1:0]];
        end
    end

    // Burst load: replacement text or the oldest window bytes
    for (genvar g = 0; g < BURST_D; g++)
    begin : g_ld
        logic [7:0] repl_b;
        logic [7:0] win_b;
        if (g < REPL_LEN)
        begin : g_r
            assign repl_b = REPL_TEXT[g];
        end
        else
        begin : g_rz
            assign repl_b = '0;
        end
        if (g < MAX_PATTERN)
        begin : g_w
            assign win_b = app[g];
        end
        else
        begin : g_wz
            assign win_b = '0;
        end
        assign ld_data[g] = censor ? repl_b : win_b;
    end

    assign ld_count = censor ? BCNT_W'(REPL_LEN) : BCNT_W'(n_pop);
    assign ld_eos   = item_eos;

    // Window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (step)
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            win_reg <= win_next;
    end

endmodule

### hw/rtl/swc_burst.sv
// Output sequencer: holds one burst of result bytes, drains a byte per cycle while out_ready is high.
module swc_burst #(
    parameter int BURST_D = 32,
    parameter int BCNT_W  = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic [7:0]        ld_data [BURST_D],
    input  logic [BCNT_W-1:0] ld_count,
    input  logic              ld_eos,
    output logic              can_load,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic              run_last,
    output logic              stream_done
);
    import swc_pkg::*;

    logic [7:0]        data_reg [BURST_D];
    logic [BCNT_W-1:0] cnt_reg;
    logic              eos_reg;
    logic              out_fire;

    assign out_valid   = (cnt_reg != '0);
    assign out_fire    = out_valid && out_ready;
    assign can_load    = (cnt_reg == '0) || (cnt_reg == BCNT_W'(1) && out_ready);
    assign out_byte    = data_reg[0];
    assign run_last    = (cnt_reg == BCNT_W'(1));
    assign stream_done = run_last && eos_reg;

    // Remaining count and end-of-stream mark
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            eos_reg <= 1'b0;
        end
        else if (load)
        begin
            cnt_reg <= ld_count;
            eos_reg <= ld_eos;
        end
        else if (out_fire)
        begin
            cnt_reg <= cnt_reg - BCNT_W'(1);
        end
    end

    // Byte shift line, head is the current result
    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= ld_data;
        else if (out_fire)
        begin
            for (int i = 0; i < BURST_D - 1; i++)
                data_reg[i] <= data_reg[i+1];
            data_reg[BURST_D-1] <= '0;
        end
    end

endmodule

### hw/rtl/stream_word_censor_top.sv
// Top level of the stream word censor: input register, match window, output sequencer.
//
// Streaming find-and-replace: each leftmost, non-overlapping occurrence of the
// configured pattern (1 to MAX_PATTERN bytes) is replaced by "CENSORED"; other
// bytes pass in order. A byte enters the input register, is matched against the
// whole window in parallel, and its results load the output sequencer, which
// drains one byte per cycle while out_ready is high. Throughput is one input
// byte per cycle while each byte yields at most one result and out_ready is
// high; a request with more results (eight for a replacement, up to the window
// length for an end-of-stream flush) holds the sequencer until they drain, and
// input waits behind it. Requests that yield no result pass without waiting.
// Program the pattern registers only while the block is idle.
module stream_word_censor_top #(
    parameter int MAX_PATTERN = swc_pkg::MAX_PATTERN_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [swc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [swc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      in_byte,
    input  logic                            end_of_stream,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      out_byte,
    output logic                            run_last,
    output logic                            stream_done
);
    import swc_pkg::*;

    localparam int BURST_D = (MAX_PATTERN > REPL_LEN) ? MAX_PATTERN : REPL_LEN;
    localparam int BCNT_W  = $clog2(BURST_D + 1);

    logic              vld_reg;
    logic [7:0]        byte_reg;
    logic              eos_reg;
    logic              advance;
    logic              can_load;
    logic [7:0]        ld_data [BURST_D];
    logic [BCNT_W-1:0] ld_count;
    logic              ld_eos;

    // Held request moves on when it makes no result or the sequencer is free
    assign advance  = vld_reg && (can_load || ld_count == '0);
    assign in_ready = !vld_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (in_valid && in_ready)
            vld_reg <= 1'b1;
        else if (advance)
            vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= in_byte;
            eos_reg  <= end_of_stream;
        end
    end

    swc_window #(
        .MAX_PATTERN (MAX_PATTERN),
        .BURST_D     (BURST_D),
        .BCNT_W      (BCNT_W)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (advance),
        .item_byte (byte_reg),
        .item_eos  (eos_reg),
        .ld_data   (ld_data),
        .ld_count  (ld_count),
        .ld_eos    (ld_eos)
    );

    swc_burst #(
        .BURST_D (BURST_D),
        .BCNT_W  (BCNT_W)
    ) u_burst (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance && ld_count != '0),
        .ld_data     (ld_data),
        .ld_count    (ld_count),
        .ld_eos      (ld_eos),
        .can_load    (can_load),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .run_last    (run_last),
        .stream_done (stream_done)
    );

endmodule

### hw/rtl/swc_checker.sv
// Port-level checks for the stream word censor, bound to the top level.
module swc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       run_last,
    input logic       stream_done
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(run_last) && $stable(stream_done))
        else $error("result changed while stalled");

    // End of stream only on the last byte of a burst
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stream_done |-> run_last)
        else $error("stream_done without run_last");

    // A burst drains without gaps
    a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !run_last |=> out_valid)
        else $error("gap inside a result burst");

    // Input only waits behind pending results
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result pending");

endmodule

bind stream_word_censor_top swc_checker u_swc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .run_last    (run_last),
    .stream_done (stream_done)
);

### verif/tb_top.sv
// Testbench for stream_word_censor_top: directed and random text checked against a censor model.
module tb_top;
    import swc_pkg::*;

    localparam int WIN_MAX       = MAX_PATTERN_DEF;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 200;

    typedef struct packed {
        logic [7:0] ch;
        logic       last_of_req;
        logic       done;
    } text_byte_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [7:0]            in_byte;
    logic                  end_of_stream;
    logic                  out_valid;
    logic                  out_ready;
    logic [7:0]            out_byte;
    logic                  run_last;
    logic                  stream_done;

    // Censor model state: pattern registers and the byte window
    logic [63:0]       pat_word [4];
    logic [PLEN_W-1:0] pat_len_reg;
    logic [7:0]        win_buf [WIN_MAX];
    int                win_len;

    // Censored text still owed by the block, oldest first
    text_byte_t pending_text [$];

    int mismatch_cnt;
    bit tx_steady;
    bit rx_steady;
    int rx_hold;

    always #1 clk = ~clk;

    stream_word_censor_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .end_of_stream (end_of_stream),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .run_last      (run_last),
        .stream_done   (stream_done)
    );

    // Length in use: zero acts as one, anything past the window acts as full window
    function automatic int active_len();
        int n;
        n = int'(pat_len_reg);
        if (n == 0)
            n = 1;
        if (n > WIN_MAX)
            n = WIN_MAX;
        return n;
    endfunction

    function automatic logic [7:0] pat_at(int i);
        return pat_word[i / 8][(i % 8) * 8 +: 8];
    endfunction

    // Pass the oldest window byte through unchanged
    function automatic void emit_oldest();
        text_byte_t r;
        if (win_len > 0)
        begin
            r.ch          = win_buf[0];
            r.last_of_req = 1'b0;
            r.done        = 1'b0;
            pending_text.push_back(r);
            for (int i = 0; i < WIN_MAX - 1; i++)
                win_buf[i] = win_buf[i + 1];
            win_buf[WIN_MAX - 1] = 8'h00;
            win_len--;
        end
    endfunction

    // One accepted byte: append, compare or shift, flush at end of stream
    function automatic void censor_byte(logic [7:0] b, logic eos);
        int         n;
        int         start_at;
        bit         hit;
        text_byte_t r;
        n        = active_len();
        start_at = pending_text.size();
        if (win_len >= WIN_MAX)
            emit_oldest();
        win_buf[win_len] = b;
        win_len++;
        if (win_len > n)
        begin
            // length lowered under a partly filled window
            while (win_len > n - 1)
                emit_oldest();
        end
        else if (win_len == n)
        begin
            hit = 1'b1;
            for (int i = 0; i < n; i++)
                if (win_buf[i] != pat_at(i))
                    hit = 1'b0;
            if (hit)
            begin
                for (int i = 0; i < REPL_LEN; i++)
                begin
                    r.ch          = REPL_TEXT[i];
                    r.last_of_req = 1'b0;
                    r.done        = 1'b0;
                    pending_text.push_back(r);
                end
                for (int i = 0; i < WIN_MAX; i++)
                    win_buf[i] = 8'h00;
                win_len = 0;
            end
            else
                emit_oldest();
        end
        if (eos)
        begin
            while (win_len > 0)
                emit_oldest();
            for (int i = 0; i < WIN_MAX; i++)
                win_buf[i] = 8'h00;
        end
        // mark the last byte of this request
        if (pending_text.size() > start_at)
        begin
            r             = pending_text[pending_text.size() - 1];
            r.last_of_req = 1'b1;
            r.done        = eos;
            pending_text[pending_text.size() - 1] = r;
        end
    endfunction

    // Register write while idle, mirrored into the model
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_PATTERN_WORD_0: pat_word[0] = val;
            REG_PATTERN_WORD_1: pat_word[1] = val;
            REG_PATTERN_WORD_2: pat_word[2] = val;
            REG_PATTERN_WORD_3: pat_word[3] = val;
            REG_PATTERN_LENGTH: pat_len_reg = val[PLEN_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic load_pattern(input logic [255:0] bytes, input logic [63:0] len_data);
        write_reg(REG_PATTERN_WORD_0, bytes[63:0]);
        write_reg(REG_PATTERN_WORD_1, bytes[127:64]);
        write_reg(REG_PATTERN_WORD_2, bytes[191:128]);
        write_reg(REG_PATTERN_WORD_3, bytes[255:192]);
        write_reg(REG_PATTERN_LENGTH, len_data);
    endtask

    // Send one byte request; valid stays high if the next one follows at once
    task automatic send_byte(input logic [7:0] b, input logic eos);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 16);
        if ($urandom_range(0, 31) == 0)
            tx_steady = !tx_steady;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        in_byte       <= b;
        end_of_stream <= eos;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        censor_byte(b, eos);
    endtask

    // Drop valid, wait for all owed text, then let the pipeline drain
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_text.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Compare one accepted output byte with the oldest owed one
    task automatic check_text_byte();
        text_byte_t want;
        if (pending_text.size() == 0)
        begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("unexpected output: byte %h run_last %b stream_done %b",
                         out_byte, run_last, stream_done);
        end
        else
        begin
            want = pending_text.pop_front();
            if (out_byte !== want.ch || run_last !== want.last_of_req ||
                stream_done !== want.done)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("output mismatch: expected %h/%b/%b got %h/%b/%b",
                             want.ch, want.last_of_req, want.done,
                             out_byte, run_last, stream_done);
            end
        end
    endtask

    // Output side: check each accepted byte, then stall a random while
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_hold = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                check_text_byte();
                rx_hold = rx_steady ? 0 : $urandom_range(0, 16);
                if ($urandom_range(0, 31) == 0)
                    rx_steady = !rx_steady;
            end
            else if (rx_hold > 0)
                rx_hold--;
            out_ready <= (rx_hold == 0);
        end
    end

    // Reset registers: zero pattern, length one, so a zero byte is censored
    task automatic test_reset_defaults();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        settle();
    endtask

    // Failed compare shifts one byte, then the shifted window matches
    task automatic test_shifted_match();
        logic [255:0] pat;
        pat         = {8{$urandom}};
        pat[7:0]    = "a";
        pat[15:8]   = "a";
        pat[23:16]  = "b";
        load_pattern(pat, 64'd3);
        send_byte("a", 1'b0);
        send_byte("a", 1'b0);
        send_byte("a", 1'b0);
        send_byte("b", 1'b1);
        settle();
    endtask

    // Length code zero behaves as one; upper data bits are ignored
    task automatic test_length_zero();
        logic [255:0] pat;
        pat      = {8{$urandom}};
        pat[7:0] = "x";
        load_pattern(pat, 64'hFFFF_FFFF_FFFF_FFC0);
        send_byte("x", 1'b0);
        send_byte("y", 1'b1);
        settle();
    endtask

    // Length code above the window clamps to the full window
    task automatic test_length_overflow();
        logic [255:0] pat;
        pat = {8{$urandom}};
        load_pattern(pat, 64'h3F);
        send_byte(8'($urandom), 1'b0);
        send_byte(8'($urandom), 1'b0);
        send_byte(8'($urandom), 1'b1);
        settle();
    endtask

    // Length lowered with four bytes held: they pass out, then the new length matches
    task automatic test_length_lowered();
        logic [255:0] pat;
        pat       = {8{$urandom}};
        pat[7:0]  = 8'h5A;
        pat[15:8] = 8'hA5;
        load_pattern(pat, 64'd6);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b0);
        send_byte(8'h44, 1'b0);
        settle();
        write_reg(REG_PATTERN_LENGTH, 64'd2);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hA5, 1'b1);
        settle();
    endtask

    // Pattern rewritten mid-stream: the held bytes are compared against the new one
    task automatic test_pattern_changed();
        logic [255:0] pat;
        logic [63:0]  w;
        pat        = {8{$urandom}};
        pat[7:0]   = "W";
        pat[15:8]  = "X";
        pat[23:16] = "Y";
        pat[31:24] = "Z";
        load_pattern(pat, 64'd4);
        send_byte("W", 1'b0);
        send_byte("X", 1'b0);
        settle();
        w        = pat[63:0];
        w[23:16] = "Q";
        w[31:24] = "R";
        write_reg(REG_PATTERN_WORD_0, w);
        send_byte("Q", 1'b0);
        send_byte("R", 1'b1);
        settle();
    endtask

    // Random phases: new pattern, then streams built mostly from pattern pieces
    task automatic test_random_text();
        int           sent;
        int           n_eff;
        int           n_code;
        int           streams;
        int           target;
        int           k;
        int           alpha;
        bit           narrow;
        bit           keep_open;
        logic [7:0]   base;
        logic [255:0] pat;
        logic [63:0]  len_data;
        logic [7:0]   txt [$];
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            // pattern over a tiny alphabet half the time, so partial matches are common
            narrow = ($urandom_range(0, 1) == 1);
            base   = 8'($urandom);
            alpha  = $urandom_range(2, 4);
            for (int i = 0; i < WIN_MAX; i++)
                pat[8 * i +: 8] = narrow ? 8'(base + $urandom_range(0, alpha - 1))
                                         : 8'($urandom);
            case ($urandom_range(0, 11))
                0:       n_code = 0;
                1:       n_code = $urandom_range(33, 63);
                2:       n_code = WIN_MAX;
                3:       n_code = $urandom_range(9, 31);
                default: n_code = $urandom_range(1, 8);
            endcase
            len_data      = {$urandom, $urandom};
            len_data[5:0] = 6'(n_code);
            load_pattern(pat, len_data);
            n_eff   = active_len();
            streams = $urandom_range(1, 3);
            for (int s = 0; s < streams; s++)
            begin
                target = $urandom_range(1, 40);
                txt.delete();
                while (txt.size() < target)
                begin
                    case ($urandom_range(0, 7))
                        0, 1:
                            for (int i = 0; i < n_eff; i++)
                                txt.push_back(pat_at(i));
                        2:
                        begin
                            k = $urandom_range(1, n_eff);
                            for (int i = 0; i < k; i++)
                                txt.push_back(pat_at(i));
                        end
                        3:
                        begin
                            // near miss: one bit flipped somewhere in a full copy
                            k = $urandom_range(0, n_eff - 1);
                            for (int i = 0; i < n_eff; i++)
                                txt.push_back(i == k ?
                                    8'(pat_at(i) ^ (8'h01 << $urandom_range(0, 7))) :
                                    pat_at(i));
                        end
                        4:
                            txt.push_back(narrow ? 8'(base + $urandom_range(0, alpha - 1))
                                                 : 8'($urandom));
                        5:
                            txt.push_back(8'($urandom));
                        default:
                            txt.push_back(pat_at($urandom_range(0, n_eff - 1)));
                    endcase
                end
                // sometimes leave the last stream open across the next pattern change
                keep_open = (s == streams - 1) && ($urandom_range(0, 3) == 0);
                for (int j = 0; j < txt.size(); j++)
                    send_byte(txt[j], (j == txt.size() - 1) && !keep_open);
                sent += txt.size();
            end
            settle();
        end
    endtask

    // Run guard
    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = REG_PATTERN_WORD_0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        in_byte       = 8'h00;
        end_of_stream = 1'b0;
        out_ready     = 1'b0;
        mismatch_cnt  = 0;
        tx_steady     = 1'b0;
        rx_steady     = 1'b0;
        rx_hold       = 0;
        for (int i = 0; i < 4; i++)
            pat_word[i] = '0;
        pat_len_reg = 6'd1;
        for (int i = 0; i < WIN_MAX; i++)
            win_buf[i] = 8'h00;
        win_len = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_shifted_match();
        test_length_zero();
        test_length_overflow();
        test_length_lowered();
        test_pattern_changed();
        test_random_text();

        settle();
        repeat (16) @(posedge clk);
        if (mismatch_cnt == 0 && pending_text.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
